// ===== hw/rtl/rgtd_pkg.sv =====
// Shared types, codes and helpers for the rate group task dispatcher.
package rgtd_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW     = $clog2(MaxTasks + 1);
  localparam int NumGroups = 4;
  localparam int NumDiv    = 3;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [2:0]      cls_t;
  typedef logic [2:0]      req_t;
  typedef logic [3:0]      tid_t;
  typedef logic [4:0]      mem_t;
  typedef logic [3:0]      ratio_t;
  typedef logic [1:0]      grp_t;

  // task classes
  localparam cls_t ClsIdle   = 3'd0;
  localparam cls_t ClsEvent  = 3'd1;
  localparam cls_t ClsRate0  = 3'd2;
  localparam cls_t ClsRate3  = 3'd5;
  localparam cls_t ClsRing   = 3'd6;
  localparam cls_t ClsParked = 3'd7;

  // request types
  localparam req_t ReqTick     = 3'd0;
  localparam req_t ReqDispatch = 3'd1;
  localparam req_t ReqAdd      = 3'd2;
  localparam req_t ReqSetEvent = 3'd3;
  localparam req_t ReqSleep    = 3'd4;
  localparam req_t ReqActivate = 3'd5;

  localparam mem_t   MemberMax  = 5'd31;
  localparam ratio_t RatioReset = 4'd10;

  typedef struct packed {
    logic latch;  // capture the incoming request
    logic exec;   // apply the captured request and load the result register
  } dp_cmd_t;

  function automatic logic is_rate(cls_t c);
    return (c >= ClsRate0) && (c <= ClsRate3);
  endfunction

  function automatic grp_t grp_of(cls_t c);
    cls_t diff;
    diff = c - ClsRate0;
    return diff[1:0];
  endfunction

endpackage

// ===== hw/rtl/rgtd_ctrl.sv =====
// Request sequencer: capture, execute, and result register handshake.
module rgtd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rgtd_pkg::dp_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;

  assign in_ready_o = (state_q == StIdle);
  // result register must be free (or draining this cycle) before execute
  assign exec = (state_q == StExec) && (!out_valid_q || out_ready_i);

  assign cmd_o.latch = in_valid_i && in_ready_o;
  assign cmd_o.exec  = exec;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: if (exec) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("execute did not produce a result");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted request not moved to execute");

  a_hold_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StExec) && out_valid_o && !out_ready_i) |=>
      ((state_q == StExec) && !in_ready_o))
    else $error("execute left while result register full");
`endif

endmodule

// ===== hw/rtl/rgtd_dpath.sv =====
// Datapath: class table, counters, rate group budgets and dividers (ratio ten after reset).
module rgtd_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rgtd_pkg::dp_cmd_t cmd_i,
  input  logic [2:0]        req_type_i,
  input  logic [3:0]        task_index_i,
  input  logic [2:0]        task_class_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  output logic              dispatch_valid_o,
  output logic [3:0]        task_id_o,
  output logic              overflow_o
);

  rgtd_pkg::req_t   req_q;
  logic [3:0]       idx_q;
  rgtd_pkg::cls_t   cls_q;

  rgtd_pkg::cls_t   tab_q [rgtd_pkg::MaxTasks];
  rgtd_pkg::cnt_t   count_q, count_d;
  rgtd_pkg::cnt_t   cursor_q, cursor_d;
  rgtd_pkg::mem_t   members_q [rgtd_pkg::NumGroups];
  rgtd_pkg::mem_t   members_d [rgtd_pkg::NumGroups];
  rgtd_pkg::mem_t   budget_q  [rgtd_pkg::NumGroups];
  rgtd_pkg::mem_t   budget_d  [rgtd_pkg::NumGroups];
  rgtd_pkg::ratio_t div_q     [rgtd_pkg::NumDiv];
  rgtd_pkg::ratio_t div_d     [rgtd_pkg::NumDiv];
  rgtd_pkg::ratio_t ratio_q;

  logic             dv_q, dv_d, ovf_q, ovf_d;
  rgtd_pkg::tid_t   tid_q, tid_d;

  rgtd_pkg::cnt_t   cur;
  rgtd_pkg::idx_t   raddr;
  rgtd_pkg::cls_t   rd_cls;
  logic             idx_ok;

  logic             tab_we;
  rgtd_pkg::idx_t   tab_waddr;
  rgtd_pkg::cls_t   tab_wdata;

  // cursor wraps before the lookup once it reaches the fill level
  assign cur    = (cursor_q >= count_q) ? '0 : cursor_q;
  assign raddr  = (req_q == rgtd_pkg::ReqDispatch) ? rgtd_pkg::idx_t'(cur)
                                                   : rgtd_pkg::idx_t'(idx_q);
  assign rd_cls = tab_q[raddr];
  assign idx_ok = int'(idx_q) < rgtd_pkg::MaxTasks;

  always_comb begin
    logic             carry;
    rgtd_pkg::ratio_t nd;
    rgtd_pkg::grp_t   g;

    tab_we    = 1'b0;
    tab_waddr = raddr;
    tab_wdata = rgtd_pkg::ClsIdle;
    count_d   = count_q;
    cursor_d  = cursor_q;
    members_d = members_q;
    budget_d  = budget_q;
    div_d     = div_q;
    dv_d      = 1'b0;
    tid_d     = '0;
    ovf_d     = 1'b0;
    carry     = 1'b1;
    nd        = '0;
    g         = '0;

    unique case (req_q)
      rgtd_pkg::ReqTick: begin
        if (budget_q[0] == '0) budget_d[0] = members_q[0];
        for (int k = 0; k < rgtd_pkg::NumDiv; k++) begin
          if (carry) begin
            nd = div_q[k] - 4'd1;
            if (nd == '0) begin
              div_d[k] = ratio_q;
              if (budget_q[k+1] == '0) budget_d[k+1] = members_q[k+1];
            end else begin
              div_d[k] = nd;
              carry    = 1'b0;
            end
          end
        end
      end
      rgtd_pkg::ReqDispatch: begin
        if (count_q != '0) begin
          g = rgtd_pkg::grp_of(rd_cls);
          priority if (rd_cls == rgtd_pkg::ClsEvent) begin
            tab_we    = 1'b1;
            tab_wdata = rgtd_pkg::ClsIdle;
            dv_d      = 1'b1;
          end else if (rd_cls == rgtd_pkg::ClsRing) begin
            dv_d = 1'b1;
          end else if (rgtd_pkg::is_rate(rd_cls) && (budget_q[g] != '0)) begin
            budget_d[g] = budget_q[g] - 5'd1;
            dv_d        = 1'b1;
          end else begin
            dv_d = 1'b0;
          end
          if (dv_d) tid_d = rgtd_pkg::tid_t'(cur);
          cursor_d = rgtd_pkg::cnt_t'(cur + 1'b1);
        end
      end
      rgtd_pkg::ReqAdd: begin
        if (int'(count_q) >= rgtd_pkg::MaxTasks) begin
          ovf_d = 1'b1;
        end else begin
          g = rgtd_pkg::grp_of(cls_q);
          if (rgtd_pkg::is_rate(cls_q) && (members_q[g] < rgtd_pkg::MemberMax)) begin
            members_d[g] = members_q[g] + 5'd1;
          end
          tab_we    = 1'b1;
          tab_waddr = rgtd_pkg::idx_t'(count_q);
          tab_wdata = (cls_q == rgtd_pkg::ClsEvent) ? rgtd_pkg::ClsIdle : cls_q;
          tid_d     = rgtd_pkg::tid_t'(count_q);
          count_d   = count_q + 1'b1;
        end
      end
      rgtd_pkg::ReqSetEvent: begin
        if (idx_ok) begin
          tab_we    = 1'b1;
          tab_wdata = rgtd_pkg::ClsEvent;
        end
      end
      rgtd_pkg::ReqSleep: begin
        if (idx_ok) begin
          g = rgtd_pkg::grp_of(rd_cls);
          if (rd_cls == rgtd_pkg::ClsRing) begin
            tab_we = 1'b1;
          end else if (rgtd_pkg::is_rate(rd_cls)) begin
            if (members_q[g] != '0) members_d[g] = members_q[g] - 5'd1;
            tab_we = 1'b1;
          end
        end
      end
      rgtd_pkg::ReqActivate: begin
        if (idx_ok && (rd_cls == rgtd_pkg::ClsIdle)) begin
          g         = rgtd_pkg::grp_of(cls_q);
          tab_we    = 1'b1;
          tab_wdata = cls_q;
          if (rgtd_pkg::is_rate(cls_q) && (members_q[g] < rgtd_pkg::MemberMax)) begin
            members_d[g] = members_q[g] + 5'd1;
          end
        end
      end
      default: begin
        // undefined request codes leave state alone
      end
    endcase
  end

  // captured request and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_type_i;
      idx_q <= task_index_i;
      cls_q <= task_class_i;
    end
    if (cmd_i.exec) begin
      dv_q  <= dv_d;
      tid_q <= tid_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rgtd_pkg::MaxTasks; i++) tab_q[i] <= rgtd_pkg::ClsIdle;
      for (int i = 0; i < rgtd_pkg::NumGroups; i++) begin
        members_q[i] <= '0;
        budget_q[i]  <= '0;
      end
      for (int i = 0; i < rgtd_pkg::NumDiv; i++) div_q[i] <= rgtd_pkg::RatioReset;
      count_q  <= '0;
      cursor_q <= '0;
    end else if (cmd_i.exec) begin
      if (tab_we) tab_q[tab_waddr] <= tab_wdata;
      members_q <= members_d;
      budget_q  <= budget_d;
      div_q     <= div_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= rgtd_pkg::RatioReset;
    end else if (cfg_we_i) begin
      ratio_q <= cfg_wdata_i;
    end
  end

  assign dispatch_valid_o = dv_q;
  assign task_id_o        = tid_q;
  assign overflow_o       = ovf_q;

endmodule

// ===== hw/rtl/rate_group_task_dispatcher_top.sv =====
// Top level of the rate group task dispatcher.
//
//   channel   handshake                 payload
//   -------   -----------------------   ---------------------------------------
//   in        in_valid_i / in_ready_o   req_type_i, task_index_i, task_class_i
//   out       out_valid_o / out_ready_i dispatch_valid_o, task_id_o, overflow_o
//   cfg       cfg_we_i (no wait)        cfg_wdata_i (divide ratio)
//
// Each request is first captured, then applied to the table and counters,
// which also loads the result register. A new request is taken in the
// cycle after execute, so no request is accepted while the last one is
// still pending. Execute waits while the result register holds an untaken
// result. Reset is asynchronous and clears all table and counter state at
// once; no clearing pass.
module rate_group_task_dispatcher_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic [3:0] task_index_i,
  input  logic [2:0] task_class_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       dispatch_valid_o,
  output logic [3:0] task_id_o,
  output logic       overflow_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  rgtd_pkg::dp_cmd_t cmd;

  rgtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  rgtd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .task_index_i    (task_index_i),
    .task_class_i    (task_class_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .dispatch_valid_o(dispatch_valid_o),
    .task_id_o       (task_id_o),
    .overflow_o      (overflow_o)
  );

endmodule
